// File: sv/htw_pkg.sv
// shared types and constants of the hierarchical timer wheel
// no dependencies
package htw_pkg;

  localparam int PTR_W = 7;
  localparam int ID_PORT_W = 6;
  localparam int TIME_W = 32;
  localparam int NUM_LEVELS = 4;
  localparam int LVL_W = 2;

  localparam logic [PTR_W-1:0] NIL = 7'h40;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  // head and tail of one slot list
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
  } slot_word_t;

  localparam slot_word_t SLOT_EMPTY = '{head: NIL, tail: NIL};

endpackage

// File: sv/htw_if.sv
// request and response channel interfaces of the timer wheel
// depends on htw_pkg
interface htw_req_if;
  import htw_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [ID_PORT_W-1:0] timer_id;
  logic [TIME_W-1:0] delay;
  modport source (output valid, operation, timer_id, delay, input ready);
  modport sink (input valid, operation, timer_id, delay, output ready);
endinterface

interface htw_rsp_if;
  import htw_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [ID_PORT_W-1:0] timer_id_res;
  logic last;
  modport source (output valid, kind, timer_id_res, last, input ready);
  modport sink (input valid, kind, timer_id_res, last, output ready);
endinterface

// File: sv/htw_ram.sv
// simple dual port synchronous ram, read first, registered read data
// no dependencies
module htw_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end
endmodule

// File: sv/hierarchical_timer_wheel.sv
// top level of the four level hierarchical timer wheel: sequencer and slot memories
// depends on htw_pkg, htw_if (htw_req_if, htw_rsp_if) and htw_ram
//
// Each request beat (tick, add, cancel) is handled one at a time by a sequencer
// that works on four memories with registered reads: near slot lists, level slot
// lists (head and tail per slot), entry next pointers and entry expiries.
// The sequencer walks these linked lists one memory access per step; a tick
// expires each live entry of the current near slot (stalling while the sink
// stalls), and when a level slot cascades it re-files each entry from it.
// After reset a clearing pass empties the slot memories before the first
// request is taken. Result beats leave through an output register, so a
// response may wait on the sink while the next request is taken; a tick's
// last expiry carries last = 1.
module hierarchical_timer_wheel #(
  parameter int NEAR_BITS = 8,
  parameter int LEVEL_BITS = 6,
  parameter int TIMER_COUNT = 64
) (
  input logic clk,
  input logic rst,
  htw_req_if.sink req,
  htw_rsp_if.source rsp
);
  import htw_pkg::*;

  localparam int NEAR_SLOTS = 1 << NEAR_BITS;
  localparam int LVL_SLOTS = NUM_LEVELS << LEVEL_BITS;
  localparam int LA_W = LEVEL_BITS + LVL_W;
  localparam int ID_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CLR_DEPTH = (NEAR_SLOTS > LVL_SLOTS) ? NEAR_SLOTS : LVL_SLOTS;
  localparam int CLR_W = $clog2(CLR_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);
  localparam logic [PTR_W-1:0] TC_P = PTR_W'(TIMER_COUNT);
  localparam logic [63:0] NEAR_MASK = 64'((64'd1 << NEAR_BITS) - 64'd1);
  localparam logic [63:0] LVL_MASK = 64'((64'd1 << LEVEL_BITS) - 64'd1);

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_RESP  = 16'h0004,
    S_NRD   = 16'h0008,
    S_NHEAD = 16'h0010,
    S_NWALK = 16'h0020,
    S_NNXT  = 16'h0040,
    S_NEMIT = 16'h0080,
    S_ADV   = 16'h0100,
    S_CHEAD = 16'h0200,
    S_CWALK = 16'h0400,
    S_CNXT  = 16'h0800,
    S_FILE  = 16'h1000,
    S_FAPP  = 16'h2000,
    S_FLINK = 16'h4000,
    S_TEND  = 16'h8000
  } state_t;

  state_t state;

  // control registers
  logic [CLR_W-1:0] clr_cnt;
  logic [TIME_W-1:0] now;
  logic [TIMER_COUNT-1:0] busy;
  logic [TIMER_COUNT-1:0] cancelled;
  logic phase2;
  logic ret_add;
  logic pend_valid;
  logic out_valid;

  // payload registers
  logic [PTR_W-1:0] cur;
  logic [PTR_W-1:0] cur_nxt;
  logic [PTR_W-1:0] link_tail;
  logic [TIME_W-1:0] exp_r;
  logic [1:0] resp_kind;
  logic [ID_PORT_W-1:0] resp_id;
  logic [ID_PORT_W-1:0] pend_id;
  logic tgt_near;
  logic [NEAR_BITS-1:0] tgt_naddr;
  logic [LA_W-1:0] tgt_laddr;
  logic [1:0] out_kind;
  logic [ID_PORT_W-1:0] out_id;
  logic out_last;

  // memory ports
  logic n_we, l_we, x_we, e_we;
  logic [NEAR_BITS-1:0] n_waddr, n_raddr;
  logic [LA_W-1:0] l_waddr, l_raddr;
  logic [ID_W-1:0] x_waddr, x_raddr, e_waddr, e_raddr;
  slot_word_t n_wdata, n_rdata, l_wdata, l_rdata;
  logic [PTR_W-1:0] x_wdata, x_rdata;
  logic [TIME_W-1:0] e_wdata, e_rdata;

  htw_ram #(.WIDTH(2 * PTR_W), .DEPTH(NEAR_SLOTS)) u_near (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );
  htw_ram #(.WIDTH(2 * PTR_W), .DEPTH(LVL_SLOTS)) u_level (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );
  htw_ram #(.WIDTH(PTR_W), .DEPTH(TIMER_COUNT)) u_next (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );
  htw_ram #(.WIDTH(TIME_W), .DEPTH(TIMER_COUNT)) u_expiry (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  logic [ID_W-1:0] req_idx;
  logic [ID_W-1:0] cur_idx;
  logic req_id_ok;
  logic req_acc;
  logic out_free;

  assign req_idx = req.timer_id[ID_W-1:0];
  assign cur_idx = cur[ID_W-1:0];
  assign req_id_ok = {1'b0, req.timer_id} < TC_P;
  assign req.ready = (state == S_IDLE);
  assign req_acc = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // cascade target after the clock advanced: first level whose lower bits
  // all rolled over and whose own digit is not zero; level 3 slot 0 on wrap
  logic c_found;
  logic [LA_W-1:0] c_laddr;
  always_comb begin
    logic go;
    logic [63:0] t64;
    logic [63:0] n;
    c_found = 1'b0;
    c_laddr = '0;
    go = 1'b1;
    n = '0;
    t64 = {32'd0, now};
    if (now == '0) begin
      c_found = 1'b1;
      c_laddr = {LVL_W'(NUM_LEVELS - 1), LEVEL_BITS'(0)};
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (go) begin
          if ((t64 & ((64'd1 << (NEAR_BITS + l * LEVEL_BITS)) - 64'd1)) == 64'd0) begin
            n = (t64 >> (NEAR_BITS + l * LEVEL_BITS)) & LVL_MASK;
            if (n != 64'd0) begin
              c_found = 1'b1;
              c_laddr = {LVL_W'(l), n[LEVEL_BITS-1:0]};
              go = 1'b0;
            end
          end else begin
            go = 1'b0;
          end
        end
      end
    end
  end

  // filing target of exp_r relative to now
  logic f_near;
  logic [LA_W-1:0] f_laddr;
  always_comb begin
    logic [63:0] e64;
    logic [63:0] t64;
    logic [63:0] sl;
    logic [LVL_W-1:0] lvl;
    logic go;
    e64 = {32'd0, exp_r};
    t64 = {32'd0, now};
    f_near = (e64 | NEAR_MASK) == (t64 | NEAR_MASK);
    lvl = LVL_W'(NUM_LEVELS - 1);
    go = 1'b1;
    for (int l = 0; l < NUM_LEVELS - 1; l++) begin
      if (go && ((e64 >> (NEAR_BITS + (l + 1) * LEVEL_BITS)) ==
                 (t64 >> (NEAR_BITS + (l + 1) * LEVEL_BITS)))) begin
        lvl = LVL_W'(l);
        go = 1'b0;
      end
    end
    sl = (e64 >> (NEAR_BITS + 32'(lvl) * LEVEL_BITS)) & LVL_MASK;
    f_laddr = {lvl, sl[LEVEL_BITS-1:0]};
  end

  slot_word_t f_word;
  assign f_word = tgt_near ? n_rdata : l_rdata;

  // emit stall while a held expiry cannot move to the output register
  logic emit_stall;
  assign emit_stall = !cancelled[cur_idx] && pend_valid && !out_free;

  logic out_load;
  logic [1:0] out_kind_next;
  logic [ID_PORT_W-1:0] out_id_next;
  logic out_last_next;

  always_comb begin
    n_we = 1'b0;
    l_we = 1'b0;
    x_we = 1'b0;
    e_we = 1'b0;
    n_waddr = now[NEAR_BITS-1:0];
    n_raddr = now[NEAR_BITS-1:0];
    n_wdata = SLOT_EMPTY;
    l_waddr = c_laddr;
    l_raddr = c_laddr;
    l_wdata = SLOT_EMPTY;
    x_waddr = cur_idx;
    x_raddr = cur_idx;
    x_wdata = NIL;
    e_waddr = req_idx;
    e_raddr = cur_idx;
    e_wdata = now + req.delay;
    out_load = 1'b0;
    out_kind_next = KIND_EXPIRE;
    out_id_next = pend_id;
    out_last_next = 1'b0;
    unique case (state)
      S_CLEAR: begin
        n_we = 1'b1;
        n_waddr = clr_cnt[NEAR_BITS-1:0];
        l_we = 1'b1;
        l_waddr = clr_cnt[LA_W-1:0];
      end
      S_IDLE: begin
        e_we = req_acc && (req.operation == OP_ADD) && req_id_ok && !busy[req_idx];
      end
      S_RESP: begin
        out_load = out_free;
        out_kind_next = resp_kind;
        out_id_next = resp_id;
        out_last_next = 1'b1;
      end
      S_NRD: begin
        n_we = 1'b1;
      end
      S_NEMIT: begin
        out_load = !cancelled[cur_idx] && pend_valid && out_free;
      end
      S_ADV: begin
        l_we = c_found;
      end
      S_FILE: begin
        n_raddr = exp_r[NEAR_BITS-1:0];
        l_raddr = f_laddr;
      end
      S_FAPP: begin
        x_we = 1'b1;
        n_waddr = tgt_naddr;
        l_waddr = tgt_laddr;
        n_wdata = '{head: f_word.head[PTR_W-1] ? cur : f_word.head, tail: cur};
        l_wdata = n_wdata;
        n_we = tgt_near;
        l_we = !tgt_near;
      end
      S_FLINK: begin
        x_we = 1'b1;
        x_waddr = link_tail[ID_W-1:0];
        x_wdata = cur;
      end
      S_TEND: begin
        out_load = pend_valid && out_free;
        out_last_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      now <= '0;
      busy <= '0;
      cancelled <= '0;
      phase2 <= 1'b0;
      ret_add <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready && out_valid) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            cur <= {1'b0, req.timer_id};
            resp_id <= req.timer_id;
            resp_kind <= KIND_REJECT;
            exp_r <= now + req.delay;
            state <= S_RESP;
            priority case (req.operation)
              OP_TICK: begin
                phase2 <= 1'b0;
                state <= S_NRD;
              end
              OP_ADD: begin
                if (req_id_ok && !busy[req_idx]) begin
                  busy[req_idx] <= 1'b1;
                  cancelled[req_idx] <= 1'b0;
                  ret_add <= 1'b1;
                  resp_kind <= KIND_ACCEPT;
                  state <= S_FILE;
                end
              end
              OP_CANCEL: begin
                if (req_id_ok && busy[req_idx]) begin
                  cancelled[req_idx] <= 1'b1;
                  resp_kind <= KIND_ACCEPT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_NRD: begin
          state <= S_NHEAD;
        end
        S_NHEAD: begin
          cur <= n_rdata.head;
          state <= S_NWALK;
        end
        S_NWALK: begin
          if (cur[PTR_W-1]) begin
            if (phase2) begin
              state <= S_TEND;
            end else begin
              now <= now + 1'b1;
              state <= S_ADV;
            end
          end else begin
            state <= S_NNXT;
          end
        end
        S_NNXT: begin
          cur_nxt <= x_rdata;
          state <= S_NEMIT;
        end
        S_NEMIT: begin
          if (!emit_stall) begin
            if (!cancelled[cur_idx]) begin
              pend_valid <= 1'b1;
              pend_id <= cur[ID_PORT_W-1:0];
            end
            busy[cur_idx] <= 1'b0;
            cancelled[cur_idx] <= 1'b0;
            cur <= cur_nxt;
            state <= S_NWALK;
          end
        end
        S_ADV: begin
          ret_add <= 1'b0;
          if (c_found) begin
            state <= S_CHEAD;
          end else begin
            phase2 <= 1'b1;
            state <= S_NRD;
          end
        end
        S_CHEAD: begin
          cur <= l_rdata.head;
          state <= S_CWALK;
        end
        S_CWALK: begin
          if (cur[PTR_W-1]) begin
            phase2 <= 1'b1;
            state <= S_NRD;
          end else begin
            state <= S_CNXT;
          end
        end
        S_CNXT: begin
          cur_nxt <= x_rdata;
          exp_r <= e_rdata;
          state <= S_FILE;
        end
        S_FILE: begin
          tgt_near <= f_near;
          tgt_naddr <= exp_r[NEAR_BITS-1:0];
          tgt_laddr <= f_laddr;
          state <= S_FAPP;
        end
        S_FAPP: begin
          link_tail <= f_word.tail;
          if (!f_word.head[PTR_W-1]) begin
            state <= S_FLINK;
          end else if (ret_add) begin
            state <= S_RESP;
          end else begin
            cur <= cur_nxt;
            state <= S_CWALK;
          end
        end
        S_FLINK: begin
          if (ret_add) begin
            state <= S_RESP;
          end else begin
            cur <= cur_nxt;
            state <= S_CWALK;
          end
        end
        S_TEND: begin
          if (!pend_valid || out_free) begin
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= out_kind_next;
      out_id <= out_id_next;
      out_last <= out_last_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.kind = out_kind;
  assign rsp.timer_id_res = out_id;
  assign rsp.last = out_last;

  // no request is taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request taken during clearing pass");

  // a held expiry exists only while a tick is being worked on
  a_pend_in_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_NRD || state == S_NHEAD || state == S_NWALK ||
                    state == S_NNXT || state == S_NEMIT || state == S_ADV ||
                    state == S_CHEAD || state == S_CWALK || state == S_CNXT ||
                    state == S_FILE || state == S_FAPP || state == S_FLINK ||
                    state == S_TEND))
    else $error("held expiry outside a tick");

  // the clock only moves between the two near expiries of a tick
  a_now_stable: assert property (@(posedge clk) disable iff (rst)
    (state != S_NWALK) |=> $stable(now))
    else $error("clock advanced outside a tick");

  // an expired entry is idle afterwards
  a_expire_frees: assert property (@(posedge clk) disable iff (rst)
    (state == S_NEMIT && !emit_stall) |=> !busy[$past(cur_idx)])
    else $error("expired entry still busy");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the hierarchical timer wheel: directed and random
// tick/add/cancel beats checked against a cycle-free model of the wheel
// depends on htw_pkg, htw_if and the hierarchical_timer_wheel rtl
module testbench;
  import htw_pkg::*;

  localparam int NEAR_W = 8;
  localparam int LVL_BITS = 6;
  localparam int N_TIMERS = 64;
  localparam int TOP_LVL = 3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [1:0] kind;
    logic [5:0] id;
    logic last;
  } wheel_event_t;

  // model of the wheel plus the queue of events it still owes
  class wheel_scoreboard;
    logic [31:0] tick_now;
    logic [6:0] near_head[256], near_tail[256];
    logic [6:0] lvl_head[256], lvl_tail[256];
    logic [6:0] link[N_TIMERS];
    logic [31:0] due[N_TIMERS];
    bit armed[N_TIMERS], killed[N_TIMERS];
    wheel_event_t owed[$];
    wheel_event_t batch[$];
    int mismatches;
    int events_seen;

    function new();
      tick_now = '0;
      for (int i = 0; i < 256; i++) begin
        near_head[i] = NIL; near_tail[i] = NIL;
        lvl_head[i] = NIL; lvl_tail[i] = NIL;
      end
      for (int i = 0; i < N_TIMERS; i++) begin
        link[i] = '0; due[i] = '0; armed[i] = 0; killed[i] = 0;
      end
      mismatches = 0;
      events_seen = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void chain_near(int s, int id);
      link[id] = NIL;
      if (near_head[s] >= N_TIMERS) near_head[s] = 7'(id);
      else link[near_tail[s][5:0]] = 7'(id);
      near_tail[s] = 7'(id);
    endfunction

    function void chain_level(int s, int id);
      link[id] = NIL;
      if (lvl_head[s] >= N_TIMERS) lvl_head[s] = 7'(id);
      else link[lvl_tail[s][5:0]] = 7'(id);
      lvl_tail[s] = 7'(id);
    endfunction

    // place an armed entry in the near wheel or the first level that spans it
    function void place(int id);
      logic [31:0] e;
      logic [63:0] span;
      int lvl;
      e = due[id];
      if ((e | 32'hFF) == (tick_now | 32'hFF)) begin
        chain_near(e[7:0], id);
        return;
      end
      span = 64'd256 << LVL_BITS;
      for (lvl = 0; lvl < TOP_LVL; lvl++) begin
        if (({32'd0, e} | (span - 1)) == ({32'd0, tick_now} | (span - 1))) break;
        span = span << LVL_BITS;
      end
      chain_level(lvl * 64 + ((e >> (NEAR_W + lvl * LVL_BITS)) & 63), id);
    endfunction

    function void refile(int lvl, int slot);
      int s, id, nx;
      s = (lvl & 3) * 64 + (slot & 63);
      id = lvl_head[s];
      lvl_head[s] = NIL; lvl_tail[s] = NIL;
      while (id < N_TIMERS) begin
        nx = link[id];
        place(id);
        id = nx;
      end
    endfunction

    function void step_clock();
      logic [31:0] v;
      logic [63:0] span;
      tick_now = tick_now + 1;
      if (tick_now == 0) begin
        refile(TOP_LVL, 0);
        return;
      end
      span = 64'd256;
      v = tick_now >> NEAR_W;
      for (int lvl = 0; lvl <= TOP_LVL; lvl++) begin
        if (({32'd0, tick_now} & (span - 1)) != 0) break;
        if ((v & 63) != 0) begin
          refile(lvl, v & 63);
          break;
        end
        span = span << LVL_BITS;
        v = v >> LVL_BITS;
      end
    endfunction

    // expire the current near slot; cancelled entries are freed silently
    function void fire_near();
      int s, id, nx;
      wheel_event_t ev;
      s = tick_now[7:0];
      id = near_head[s];
      near_head[s] = NIL; near_tail[s] = NIL;
      while (id < N_TIMERS) begin
        nx = link[id];
        if (!killed[id] && batch.size() < 64) begin
          ev.kind = KIND_EXPIRE; ev.id = 6'(id); ev.last = 0;
          batch.push_back(ev);
        end
        armed[id] = 0; killed[id] = 0;
        id = nx;
      end
    endfunction

    function void note_request(logic [1:0] op, logic [5:0] id, logic [31:0] dly);
      wheel_event_t ev;
      batch.delete();
      if (op == OP_TICK) begin
        fire_near();
        step_clock();
        fire_near();
        if (batch.size() > 0) batch[batch.size() - 1].last = 1;
      end else begin
        ev.kind = KIND_REJECT; ev.id = id; ev.last = 1;
        if (op == OP_ADD && !armed[id]) begin
          armed[id] = 1; killed[id] = 0;
          due[id] = tick_now + dly;
          place(id);
          ev.kind = KIND_ACCEPT;
        end else if (op == OP_CANCEL && armed[id]) begin
          killed[id] = 1;
          ev.kind = KIND_ACCEPT;
        end
        batch.push_back(ev);
      end
      foreach (batch[i]) owed.push_back(batch[i]);
    endfunction

    task check_result(logic [1:0] kind, logic [5:0] id, logic last);
      wheel_event_t ev;
      events_seen++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected beat kind %0d id %0d last %0d", kind, id, last));
        return;
      end
      ev = owed.pop_front();
      if (kind !== ev.kind) report($sformatf("kind %0d, want %0d", kind, ev.kind));
      if (id !== ev.id) report($sformatf("timer id %0d, want %0d", id, ev.id));
      if (last !== ev.last) report($sformatf("last %0d, want %0d", last, ev.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  htw_req_if req ();
  htw_rsp_if rsp ();

  hierarchical_timer_wheel dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wheel_scoreboard sb = new();
  int cycles = 0;
  int beats_in = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int ticks_sent = 0;

  // monitors sample at the rising edge, before the dut's updates land
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && req.valid && req.ready) begin
      sb.note_request(req.operation, req.timer_id, req.delay);
      beats_in <= beats_in + 1;
    end
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result(rsp.kind, rsp.timer_id_res, rsp.last);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off counted down here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // drive one request beat at the falling edge and wait until it is taken
  task send_beat(logic [1:0] op, logic [5:0] id, logic [31:0] dly);
    int mark;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    mark = beats_in;
    req.valid <= 1'b1;
    req.operation <= op;
    req.timer_id <= id;
    req.delay <= dly;
    if (op == OP_TICK) ticks_sent++;
    do @(negedge clk); while (beats_in == mark);
  endtask

  // sender pause: nothing left to come, then a margin for silent work
  task drain();
    req.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function logic [31:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(40);
    if (r < 85) return $urandom_range(1500);
    if (r < 95) return $urandom_range(300000);
    return $urandom;
  endfunction

  // mostly ticks and adds with short delays so expiries and cascades happen
  task random_beat();
    int r;
    r = $urandom_range(99);
    if (r < 50) send_beat(OP_TICK, 6'($urandom), $urandom);
    else if (r < 80) send_beat(OP_ADD, 6'($urandom_range(63)), pick_delay());
    else if (r < 95) send_beat(OP_CANCEL, 6'($urandom_range(63)), $urandom);
    else send_beat(OP_UNUSED, 6'($urandom), $urandom);
  endtask

  initial begin
    req.valid = 1'b0;
    req.operation = OP_TICK;
    req.timer_id = '0;
    req.delay = '0;
    rsp.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, every operation and the corner cases
    send_beat(OP_ADD, 6'd0, 32'd0);           // zero delay fires on next tick
    send_beat(OP_TICK, 6'd0, 32'd0);
    send_beat(OP_TICK, 6'd0, 32'd0);          // nothing due
    send_beat(OP_ADD, 6'd63, 32'hFFFF_FFFF);  // wraps into a near slot
    send_beat(OP_ADD, 6'd63, 32'd5);          // busy entry rejected
    send_beat(OP_CANCEL, 6'd63, 32'd0);
    send_beat(OP_CANCEL, 6'd63, 32'hFFFF_FFFF); // cancel twice
    send_beat(OP_CANCEL, 6'd5, 32'd0);        // idle entry rejected
    send_beat(OP_UNUSED, 6'd42, 32'h5555_AAAA); // unused opcode
    send_beat(OP_ADD, 6'd1, 32'd300);         // level 0
    send_beat(OP_ADD, 6'd2, 32'd70000);       // level 1
    send_beat(OP_ADD, 6'd3, 32'h0100_0000);   // level 2
    send_beat(OP_ADD, 6'd4, 32'd1);
    send_beat(OP_ADD, 6'd6, 32'd2);
    send_beat(OP_CANCEL, 6'd6, 32'd0);        // cancelled entry freed silently
    for (int i = 10; i < 18; i++) send_beat(OP_ADD, 6'(i), 32'd2);
    send_beat(OP_TICK, 6'd0, 32'd0);
    send_beat(OP_TICK, 6'd0, 32'd0);
    drain();

    // pressure: receiver holds off while ticks and adds keep coming
    hold_left = 500;
    for (int i = 20; i < 40; i++) send_beat(OP_ADD, 6'(i), 32'd1);
    send_beat(OP_TICK, 6'd0, 32'd0);
    send_beat(OP_TICK, 6'd0, 32'd0);
    drain();

    // random phases with different idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 64; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 64; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < 31; n++) random_beat();
      drain();
    end

    $display("covered %0d request beats (%0d ticks) and %0d result beats",
             beats_in, ticks_sent, sb.events_seen);
    $display("wheel clock reached %0d ticks", sb.tick_now);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
